@@ src/ph_dual_pump_dosing_scheduler_defines.svh @@
// Assertion macros shared by the dosing scheduler.
`ifndef PH_DUAL_PUMP_DOSING_SCHEDULER_DEFINES_SVH
`define PH_DUAL_PUMP_DOSING_SCHEDULER_DEFINES_SVH

// The condition must never be true while out of reset.
`define PHDPS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define PHDPS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ src/phdps_pkg.sv @@
`default_nettype none

package phdps_pkg;

    typedef enum logic [1:0] {
        ZONE_OK   = 2'd0,
        ZONE_LOW  = 2'd1,
        ZONE_HIGH = 2'd2
    } t_zone;

    typedef enum logic [2:0] {
        CFG_PH_LOW_LIMIT       = 3'd0,
        CFG_PH_HIGH_LIMIT      = 3'd1,
        CFG_PUMP_POWER_PERCENT = 3'd2,
        CFG_ON_TIME_SECONDS    = 3'd3,
        CFG_OFF_TIME_SECONDS   = 3'd4,
        CFG_PWM_PERIOD_COUNT   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] low_limit;
        logic [10:0] high_limit;
        logic [15:0] on_seconds;
        logic [15:0] off_seconds;
        logic [15:0] duty;
    } t_cfg;

    localparam logic [10:0] PH_MAX        = 11'd1400;
    localparam logic [6:0]  POWER_FULL    = 7'd100;
    localparam logic [25:0] MS_PER_SECOND = 26'd1000;

    localparam logic [10:0] RST_LOW_LIMIT  = 11'd650;
    localparam logic [10:0] RST_HIGH_LIMIT = 11'd750;
    localparam logic [6:0]  RST_POWER      = 7'd100;
    localparam logic [15:0] RST_ON_SECONDS = 16'd10;
    localparam logic [15:0] RST_OFF_SECONDS = 16'd10;
    localparam logic [15:0] RST_PWM_PERIOD = 16'd999;
    localparam logic [22:0] RST_PRODUCT    = 23'd99900;

    // Division by 100 as multiplication by ceil(2^30 / 100), exact below 2^23.
    localparam int          DIV100_SHIFT = 30;
    localparam logic [23:0] DIV100_MUL   = 24'd10737419;

    function automatic logic [25:0] phase_ms(input logic [15:0] seconds);
        logic [25:0] ms;
        ms = 26'(seconds) * MS_PER_SECOND;
        return (ms == 26'd0) ? 26'd1 : ms;
    endfunction

endpackage

`default_nettype wire

@@ src/phdps_cfg.sv @@
`default_nettype none

module phdps_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output phdps_pkg::t_cfg    o_cfg
);

    logic [10:0] r_low_limit;
    logic [10:0] r_high_limit;
    logic [6:0]  r_power;
    logic [15:0] r_on_seconds;
    logic [15:0] r_off_seconds;
    logic [15:0] r_pwm_period;
    logic [22:0] r_product;
    logic [6:0]  w_power_clamped;
    logic [46:0] w_scaled;
    logic        w_write;

    assign o_cfg_ready = i_rst_n;
    assign w_write     = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit   <= phdps_pkg::RST_LOW_LIMIT;
            r_high_limit  <= phdps_pkg::RST_HIGH_LIMIT;
            r_power       <= phdps_pkg::RST_POWER;
            r_on_seconds  <= phdps_pkg::RST_ON_SECONDS;
            r_off_seconds <= phdps_pkg::RST_OFF_SECONDS;
            r_pwm_period  <= phdps_pkg::RST_PWM_PERIOD;
        end else if (w_write) begin
            unique case (phdps_pkg::t_cfg_idx'(i_cfg_index))
                phdps_pkg::CFG_PH_LOW_LIMIT:       r_low_limit   <= i_cfg_data[10:0];
                phdps_pkg::CFG_PH_HIGH_LIMIT:      r_high_limit  <= i_cfg_data[10:0];
                phdps_pkg::CFG_PUMP_POWER_PERCENT: r_power       <= i_cfg_data[6:0];
                phdps_pkg::CFG_ON_TIME_SECONDS:    r_on_seconds  <= i_cfg_data;
                phdps_pkg::CFG_OFF_TIME_SECONDS:   r_off_seconds <= i_cfg_data;
                phdps_pkg::CFG_PWM_PERIOD_COUNT:   r_pwm_period  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_power_clamped = (r_power > phdps_pkg::POWER_FULL) ? phdps_pkg::POWER_FULL : r_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_product <= phdps_pkg::RST_PRODUCT;
        end else begin
            r_product <= 23'(r_pwm_period) * 23'(w_power_clamped);
        end
    end

    assign w_scaled = 47'(r_product) * 47'(phdps_pkg::DIV100_MUL);

    always_comb begin
        o_cfg.low_limit   = r_low_limit;
        o_cfg.high_limit  = r_high_limit;
        o_cfg.on_seconds  = r_on_seconds;
        o_cfg.off_seconds = r_off_seconds;
        o_cfg.duty        = w_scaled[phdps_pkg::DIV100_SHIFT +: 16];
    end

endmodule

`default_nettype wire

@@ src/phdps_core.sv @@
`default_nettype none

module phdps_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire phdps_pkg::t_cfg i_cfg,
    input  wire logic            i_hold,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [10:0]     i_ph_sample,
    input  wire logic [31:0]     i_now_ms,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic                 o_low_pump_on,
    output logic                 o_high_pump_on,
    output logic [15:0]          o_compare_value,
    output logic [1:0]           o_zone_now,
    output logic                 o_dosing_phase
);

    logic                r_in_vld;
    logic [10:0]         r_ph;
    logic [31:0]         r_now;

    phdps_pkg::t_zone    r_zone;
    logic                r_phase_on;
    logic [31:0]         r_start;
    logic                r_low_run;
    logic                r_high_run;

    phdps_pkg::t_zone    n_zone;
    logic                n_phase_on;
    logic [31:0]         n_start;
    logic                n_low_run;
    logic                n_high_run;

    logic                r_out_vld;
    logic                r_out_low;
    logic                r_out_high;
    logic [15:0]         r_out_cmp;
    logic [1:0]          r_out_zone;
    logic                r_out_phase;

    logic                w_adv;
    logic                w_acc;
    logic                w_proc;
    logic [10:0]         w_ph;
    logic [10:0]         w_lo;
    logic [10:0]         w_hi;
    phdps_pkg::t_zone    w_new_zone;
    logic [31:0]         w_elapsed;
    logic                w_on_done;
    logic                w_off_done;

    assign w_adv      = !r_out_vld || i_out_ready;
    assign o_in_ready = i_rst_n && !i_hold && (!r_in_vld || w_adv);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_proc     = r_in_vld && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ph  <= i_ph_sample;
            r_now <= i_now_ms;
        end
    end

    always_comb begin
        w_ph = (r_ph > phdps_pkg::PH_MAX) ? phdps_pkg::PH_MAX : r_ph;
        if (i_cfg.low_limit > i_cfg.high_limit) begin
            w_lo = i_cfg.high_limit;
            w_hi = i_cfg.low_limit;
        end else begin
            w_lo = i_cfg.low_limit;
            w_hi = i_cfg.high_limit;
        end
        priority if (w_ph > w_hi) begin
            w_new_zone = phdps_pkg::ZONE_HIGH;
        end else if (w_ph < w_lo) begin
            w_new_zone = phdps_pkg::ZONE_LOW;
        end else begin
            w_new_zone = phdps_pkg::ZONE_OK;
        end
        w_elapsed  = r_now - r_start;
        w_on_done  = w_elapsed >= 32'(phdps_pkg::phase_ms(i_cfg.on_seconds));
        w_off_done = w_elapsed >= 32'(phdps_pkg::phase_ms(i_cfg.off_seconds));
    end

    always_comb begin
        n_zone     = r_zone;
        n_phase_on = r_phase_on;
        n_start    = r_start;
        n_low_run  = r_low_run;
        n_high_run = r_high_run;
        priority if (w_new_zone != r_zone) begin
            n_zone     = w_new_zone;
            n_phase_on = (w_new_zone != phdps_pkg::ZONE_OK);
            n_start    = r_now;
            n_low_run  = (w_new_zone == phdps_pkg::ZONE_LOW);
            n_high_run = (w_new_zone == phdps_pkg::ZONE_HIGH);
        end else if (r_zone == phdps_pkg::ZONE_OK) begin
            n_phase_on = 1'b0;
            n_start    = r_now;
            n_low_run  = 1'b0;
            n_high_run = 1'b0;
        end else if (r_phase_on) begin
            if (w_on_done) begin
                n_phase_on = 1'b0;
                n_start    = r_now;
                n_low_run  = 1'b0;
                n_high_run = 1'b0;
            end else begin
                n_low_run  = (r_zone == phdps_pkg::ZONE_LOW);
                n_high_run = (r_zone == phdps_pkg::ZONE_HIGH);
            end
        end else begin
            if (w_off_done) begin
                n_phase_on = 1'b1;
                n_start    = r_now;
                n_low_run  = (r_zone == phdps_pkg::ZONE_LOW);
                n_high_run = (r_zone == phdps_pkg::ZONE_HIGH);
            end else begin
                n_low_run  = 1'b0;
                n_high_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone     <= phdps_pkg::ZONE_OK;
            r_phase_on <= 1'b0;
            r_start    <= 32'd0;
            r_low_run  <= 1'b0;
            r_high_run <= 1'b0;
        end else if (w_proc) begin
            r_zone     <= n_zone;
            r_phase_on <= n_phase_on;
            r_start    <= n_start;
            r_low_run  <= n_low_run;
            r_high_run <= n_high_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_low   <= n_low_run;
            r_out_high  <= n_high_run;
            r_out_cmp   <= (n_low_run || n_high_run) ? i_cfg.duty : 16'd0;
            r_out_zone  <= n_zone;
            r_out_phase <= n_phase_on;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_low_pump_on   = r_out_low;
    assign o_high_pump_on  = r_out_high;
    assign o_compare_value = r_out_cmp;
    assign o_zone_now      = r_out_zone;
    assign o_dosing_phase  = r_out_phase;

endmodule

`default_nettype wire

@@ src/ph_dual_pump_dosing_scheduler.sv @@
// pH dual-pump dosing scheduler.
// Each request on the input channel carries one pH sample in hundredths of pH
// and the current millisecond time; each one yields exactly one result request
// with both pump enables, the PWM compare count, the zone and the dosing phase.
// Registers are written through the configuration channel, index 0 to 5; a
// write to any other index is accepted and ignored.
// The result is registered: the input register loads when the request is
// accepted and the result register when the result stage may advance.
// Throughput is one request per cycle while the receiver is ready and no
// configuration write is offered.
// The input channel is not ready in a cycle in which a configuration write is
// offered, so that the next sample sees the new register values.
// While the receiver stalls, the result is held and one further request is
// taken into the input register; then ready drops until the result leaves.
// Synchronous active-low reset restores the register defaults, puts the block
// in the ok zone with both pumps off, and empties both registers; neither
// channel is ready while reset is asserted.

`default_nettype none

`include "ph_dual_pump_dosing_scheduler_defines.svh"

module ph_dual_pump_dosing_scheduler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [10:0] i_ph_sample,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_low_pump_on,
    output logic             o_high_pump_on,
    output logic [15:0]      o_compare_value,
    output logic [1:0]       o_zone_now,
    output logic             o_dosing_phase
);

    phdps_pkg::t_cfg w_cfg;

    phdps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    phdps_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_hold          (i_cfg_valid),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_ph_sample     (i_ph_sample),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_low_pump_on   (o_low_pump_on),
        .o_high_pump_on  (o_high_pump_on),
        .o_compare_value (o_compare_value),
        .o_zone_now      (o_zone_now),
        .o_dosing_phase  (o_dosing_phase)
    );

    `PHDPS_ASSERT_NEVER(a_one_pump, i_clk, i_rst_n,
        o_out_valid && o_low_pump_on && o_high_pump_on, "both pumps on")
    `PHDPS_ASSERT_IMPLIES(a_pump_phase, i_clk, i_rst_n, o_out_valid,
        (o_low_pump_on || o_high_pump_on) == o_dosing_phase, "pump state disagrees with phase")
    `PHDPS_ASSERT_IMPLIES(a_low_zone, i_clk, i_rst_n, o_out_valid && o_low_pump_on,
        o_zone_now == phdps_pkg::ZONE_LOW, "low pump outside low zone")
    `PHDPS_ASSERT_IMPLIES(a_ok_idle, i_clk, i_rst_n,
        o_out_valid && o_zone_now == phdps_pkg::ZONE_OK,
        !o_dosing_phase && o_compare_value == 16'd0, "activity in ok zone")
    `PHDPS_ASSERT_IMPLIES(a_cfg_hold, i_clk, i_rst_n, i_cfg_valid, !o_in_ready,
        "input taken during configuration write")

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
module testbench;
    import phdps_pkg::*;

    localparam int          QUIET_LIMIT  = 2000;
    localparam int          CHOKE_CYCLES = 80;
    localparam int          PHASES       = 11;
    localparam int          PHASE_ITEMS  = 100;
    localparam logic [2:0]  CFG_SPARE    = 3'd7;

    typedef struct packed {
        logic        low;
        logic        high;
        logic [15:0] cmp;
        t_zone       zone;
        logic        phase;
    } dose_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [15:0] data;
        logic [10:0] ph;
        logic [31:0] now;
        bit          typed;
        dose_t       want;
    } row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [10:0] i_ph_sample = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_low_pump_on;
    logic        o_high_pump_on;
    logic [15:0] o_compare_value;
    logic [1:0]  o_zone_now;
    logic        o_dosing_phase;

    ph_dual_pump_dosing_scheduler dut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor copy of the registers and the schedule state.
    logic [10:0] low_lim;
    logic [10:0] high_lim;
    logic [6:0]  power_pct;
    logic [15:0] on_sec;
    logic [15:0] off_sec;
    logic [15:0] period_cnt;
    t_zone       dose_zone;
    logic        dose_on;
    logic [31:0] dose_start;
    logic        low_run;
    logic        high_run;

    dose_t       pending_doses[$];
    row_t        plan_q[$];
    int          mismatches = 0;
    int          quiet = 0;
    bit          tx_eager = 1'b0;
    bit          rx_eager = 1'b0;
    bit          rx_choke = 1'b0;
    logic [31:0] wall_ms = '0;
    logic [10:0] ph_focus = 11'd700;

    function automatic logic [31:0] span_ms(logic [15:0] sec);
        logic [31:0] ms;
        ms = 32'(sec) * 32'(MS_PER_SECOND);
        return (ms == 32'd0) ? 32'd1 : ms;
    endfunction

    function automatic dose_t predict_dose(logic [10:0] ph_in, logic [31:0] now);
        logic [10:0] ph;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [6:0]  pct;
        logic [15:0] duty;
        t_zone       zone_next;
        dose_t       r;
        ph = (ph_in > PH_MAX) ? PH_MAX : ph_in;
        lo = (low_lim > high_lim) ? high_lim : low_lim;
        hi = (low_lim > high_lim) ? low_lim : high_lim;
        if (ph > hi) begin
            zone_next = ZONE_HIGH;
        end else if (ph < lo) begin
            zone_next = ZONE_LOW;
        end else begin
            zone_next = ZONE_OK;
        end
        pct = (power_pct > POWER_FULL) ? POWER_FULL : power_pct;
        duty = 16'((32'(period_cnt) * 32'(pct)) / 32'(POWER_FULL));
        if (zone_next != dose_zone) begin
            dose_zone = zone_next;
            dose_on = (zone_next != ZONE_OK);
            dose_start = now;
            low_run = (zone_next == ZONE_LOW);
            high_run = (zone_next == ZONE_HIGH);
        end else if (dose_zone == ZONE_OK) begin
            low_run = 1'b0;
            high_run = 1'b0;
            dose_on = 1'b0;
            dose_start = now;
        end else if (dose_on) begin
            low_run = (dose_zone == ZONE_LOW);
            high_run = (dose_zone == ZONE_HIGH);
            if (now - dose_start >= span_ms(on_sec)) begin
                low_run = 1'b0;
                high_run = 1'b0;
                dose_on = 1'b0;
                dose_start = now;
            end
        end else if (now - dose_start >= span_ms(off_sec)) begin
            low_run = (dose_zone == ZONE_LOW);
            high_run = (dose_zone == ZONE_HIGH);
            dose_on = 1'b1;
            dose_start = now;
        end else begin
            low_run = 1'b0;
            high_run = 1'b0;
        end
        r.low = low_run;
        r.high = high_run;
        r.cmp = (low_run || high_run) ? duty : 16'd0;
        r.zone = dose_zone;
        r.phase = dose_on;
        return r;
    endfunction

    // Times cluster around the end of the running phase so that both phase
    // changes are crossed often, with jumps and wraps mixed in.
    function automatic logic [31:0] pick_now();
        logic [31:0] span;
        span = span_ms(dose_on ? on_sec : off_sec);
        case ($urandom_range(0, 9))
            0, 1, 2: wall_ms = wall_ms + $urandom_range(0, 20);
            3, 4, 5: wall_ms = dose_start + span - 32'd1 + $urandom_range(0, 1);
            6, 7: wall_ms = wall_ms + $urandom_range(0, 3 * span);
            8: wall_ms = $urandom;
            default: wall_ms = wall_ms + span;
        endcase
        return wall_ms;
    endfunction

    function automatic logic [10:0] pick_ph();
        logic [10:0] lo;
        logic [10:0] hi;
        int          v;
        lo = (low_lim > high_lim) ? high_lim : low_lim;
        hi = (low_lim > high_lim) ? low_lim : high_lim;
        case ($urandom_range(0, 9))
            7: begin
                case ($urandom_range(0, 3))
                    0: v = int'(lo) - 1;
                    1: v = int'(lo);
                    2: v = int'(hi);
                    default: v = int'(hi) + 1;
                endcase
                if (v < 0) v = 0;
                if (v > 2047) v = 2047;
                ph_focus = 11'(v);
            end
            8: ph_focus = 11'($urandom_range(0, 1400));
            9: return 11'($urandom);
            default: ;
        endcase
        return ph_focus;
    endfunction

    function automatic logic [15:0] rand_limit();
        if ($urandom_range(0, 5) == 0) return 16'($urandom);
        return {5'($urandom), 11'($urandom_range(300, 1100))};
    endfunction

    function automatic logic [15:0] rand_seconds();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_in_valid <= 1'b0;
        while (pending_doses.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PH_LOW_LIMIT: low_lim = data[10:0];
            CFG_PH_HIGH_LIMIT: high_lim = data[10:0];
            CFG_PUMP_POWER_PERCENT: power_pct = data[6:0];
            CFG_ON_TIME_SECONDS: on_sec = data;
            CFG_OFF_TIME_SECONDS: off_sec = data;
            CFG_PWM_PERIOD_COUNT: period_cnt = data;
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [10:0] ph, logic [31:0] now, bit typed, dose_t want);
        int unsigned gap;
        dose_t       got;
        gap = tx_eager ? 0 : $urandom_range(0, 10);
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ph_sample <= ph;
        i_now_ms <= now;
        do @(posedge i_clk); while (!o_in_ready);
        got = predict_dose(ph, now);
        pending_doses.push_back(typed ? want : got);
    endtask

    task automatic plan_cfg(logic [2:0] idx, logic [15:0] data);
        row_t r;
        r = '{1'b1, idx, data, 11'd0, 32'd0, 1'b0, '0};
        plan_q.push_back(r);
    endtask

    task automatic plan_in(logic [10:0] ph, logic [31:0] now);
        row_t r;
        r = '{1'b0, '0, '0, ph, now, 1'b0, '0};
        plan_q.push_back(r);
    endtask

    task automatic plan_want(logic [10:0] ph, logic [31:0] now, dose_t want);
        row_t r;
        r = '{1'b0, '0, '0, ph, now, 1'b1, want};
        plan_q.push_back(r);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        dose_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_doses.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected: low %0d high %0d cmp %0d zone %0d phase %0d",
                         $time, o_low_pump_on, o_high_pump_on, o_compare_value, o_zone_now,
                         o_dosing_phase);
            end else begin
                want = pending_doses.pop_front();
                check_field("low_pump_on", 16'(want.low), 16'(o_low_pump_on));
                check_field("high_pump_on", 16'(want.high), 16'(o_high_pump_on));
                check_field("compare_value", want.cmp, o_compare_value);
                check_field("zone_now", 16'(want.zone), 16'(o_zone_now));
                check_field("dosing_phase", 16'(want.phase), 16'(o_dosing_phase));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, quiet);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin : drain
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_choke) begin
                hold = CHOKE_CYCLES;
                rx_choke = 1'b0;
            end else begin
                hold = rx_eager ? 0 : $urandom_range(0, 10);
            end
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    initial begin : stimulus
        logic [15:0] v [6];
        low_lim = RST_LOW_LIMIT;
        high_lim = RST_HIGH_LIMIT;
        power_pct = RST_POWER;
        on_sec = RST_ON_SECONDS;
        off_sec = RST_OFF_SECONDS;
        period_cnt = RST_PWM_PERIOD;
        dose_zone = ZONE_OK;
        dose_on = 1'b0;
        dose_start = '0;
        low_run = 1'b0;
        high_run = 1'b0;

        plan_want(11'd700, 32'd0, '{1'b0, 1'b0, 16'd0, ZONE_OK, 1'b0});
        plan_want(11'd0, 32'd100, '{1'b1, 1'b0, 16'd999, ZONE_LOW, 1'b1});
        plan_want(11'd0, 32'd10099, '{1'b1, 1'b0, 16'd999, ZONE_LOW, 1'b1});
        plan_want(11'd0, 32'd10100, '{1'b0, 1'b0, 16'd0, ZONE_LOW, 1'b0});
        plan_want(11'd0, 32'd20099, '{1'b0, 1'b0, 16'd0, ZONE_LOW, 1'b0});
        plan_want(11'd0, 32'd20100, '{1'b1, 1'b0, 16'd999, ZONE_LOW, 1'b1});
        plan_want(11'd2047, 32'd20200, '{1'b0, 1'b1, 16'd999, ZONE_HIGH, 1'b1});
        plan_want(11'd1400, 32'd20300, '{1'b0, 1'b1, 16'd999, ZONE_HIGH, 1'b1});
        plan_want(11'd751, 32'd20400, '{1'b0, 1'b1, 16'd999, ZONE_HIGH, 1'b1});
        plan_want(11'd750, 32'd20500, '{1'b0, 1'b0, 16'd0, ZONE_OK, 1'b0});
        plan_want(11'd650, 32'd20600, '{1'b0, 1'b0, 16'd0, ZONE_OK, 1'b0});
        plan_want(11'd649, 32'd20700, '{1'b1, 1'b0, 16'd999, ZONE_LOW, 1'b1});
        // The on phase below runs across the wrap of the millisecond counter.
        plan_want(11'd1000, 32'hFFFF_FF00, '{1'b0, 1'b1, 16'd999, ZONE_HIGH, 1'b1});
        plan_want(11'd1000, 32'h0000_260F, '{1'b0, 1'b1, 16'd999, ZONE_HIGH, 1'b1});
        plan_want(11'd1000, 32'h0000_2610, '{1'b0, 1'b0, 16'd0, ZONE_HIGH, 1'b0});
        plan_cfg(CFG_PH_LOW_LIMIT, 16'd800);
        plan_cfg(CFG_PH_HIGH_LIMIT, 16'd600);
        plan_cfg(CFG_PUMP_POWER_PERCENT, 16'hFF7F);
        plan_cfg(CFG_ON_TIME_SECONDS, 16'd0);
        plan_cfg(CFG_OFF_TIME_SECONDS, 16'd0);
        plan_cfg(CFG_PWM_PERIOD_COUNT, 16'hFFFF);
        plan_cfg(CFG_SPARE, 16'h5A5A);
        plan_want(11'd700, 32'd1000, '{1'b0, 1'b0, 16'd0, ZONE_OK, 1'b0});
        plan_want(11'd599, 32'd1001, '{1'b1, 1'b0, 16'hFFFF, ZONE_LOW, 1'b1});
        plan_want(11'd599, 32'd1002, '{1'b0, 1'b0, 16'd0, ZONE_LOW, 1'b0});
        plan_want(11'd599, 32'd1003, '{1'b1, 1'b0, 16'hFFFF, ZONE_LOW, 1'b1});
        plan_in(11'd801, 32'd1003);
        plan_cfg(CFG_PUMP_POWER_PERCENT, 16'd0);
        plan_in(11'd1400, 32'd1004);
        plan_cfg(CFG_PH_LOW_LIMIT, 16'hF800);
        plan_cfg(CFG_PH_HIGH_LIMIT, 16'hFFFF);
        plan_cfg(CFG_PUMP_POWER_PERCENT, 16'd100);
        plan_cfg(CFG_PWM_PERIOD_COUNT, 16'd12345);
        plan_in(11'd0, 32'h8000_0000);
        plan_in(11'd2047, 32'h8000_0001);
        plan_in(11'd1234, 32'h7FFF_FFFF);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[k]) begin
            if (plan_q[k].is_cfg) begin
                write_reg(plan_q[k].idx, plan_q[k].data);
            end else begin
                send_sample(plan_q[k].ph, plan_q[k].now, plan_q[k].typed, plan_q[k].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: v = '{16'h0000, 16'h0000, 16'd100, 16'd1, 16'd2, 16'd999};
                1: v = '{16'hFFFF, 16'h07FF, 16'h007F, 16'd0, 16'd0, 16'hFFFF};
                2: v = '{16'd600, 16'd900, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
                default: begin
                    v[0] = rand_limit();
                    v[1] = rand_limit();
                    v[2] = {9'($urandom), 7'($urandom_range(0, 127))};
                    v[3] = rand_seconds();
                    v[4] = rand_seconds();
                    v[5] = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                    if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, 16'($urandom));
                end
            endcase
            write_reg(CFG_PH_LOW_LIMIT, v[0]);
            write_reg(CFG_PH_HIGH_LIMIT, v[1]);
            write_reg(CFG_PUMP_POWER_PERCENT, v[2]);
            write_reg(CFG_ON_TIME_SECONDS, v[3]);
            write_reg(CFG_OFF_TIME_SECONDS, v[4]);
            write_reg(CFG_PWM_PERIOD_COUNT, v[5]);
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            // The receiver stops for a long stretch while samples keep coming.
            if (p == 2) begin
                tx_eager = 1'b1;
                rx_eager = 1'b0;
                rx_choke = 1'b1;
            end
            wall_ms = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_ph(), pick_now(), 1'b0, '0);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_doses.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+src
src/phdps_pkg.sv
src/phdps_cfg.sv
src/phdps_core.sv
src/ph_dual_pump_dosing_scheduler.sv
verif/testbench.sv
